>>> rtl/assert_macros.svh
// Assertion macros shared by the sampler RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define USWR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// same-cycle implication
`define USWR_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define USWR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/uswr_pkg.sv
// Shared widths, codes and controller/datapath bundles for the sampler.
// No dependencies.
`timescale 1ns / 1ps

package uswr_pkg;

   localparam int OP_W   = 2;
   localparam int WORD_W = 31;
   localparam int POS_W  = 10;
   localparam int CNT_W  = 11;
   localparam int ST_W   = 2;

   localparam int REQ_TDATA_W = ((WORD_W + POS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((POS_W + CNT_W + 7) / 8) * 8;

   localparam int POOL_MAX_DEFAULT = 1024;
   localparam logic [CNT_W-1:0] POOL_COUNT_RESET = 11'd1024;

   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_DRAW   = 2'd0;
   localparam op_type OP_DELETE = 2'd1;
   localparam op_type OP_RESET  = 2'd2;

   typedef logic [ST_W-1:0] status_type;
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_EXHAUSTED = 2'd1;
   localparam status_type ST_ORDER     = 2'd2;

   typedef struct packed {
      logic capture;
      logic mod_start;
      logic set_slot;
      logic rd_en;
      logic wr_a;
      logic wr_b;
      logic sweep_wr;
      logic finish;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   exhausted;
      logic   order_bad;
      logic   mod_done;
      logic   sweep_last;
      logic   out_free;
   } stat_type;

endpackage

>>> rtl/uswr_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle.
// Depends on uswr_pkg.
`timescale 1ns / 1ps

module uswr_mod_unit
   import uswr_pkg::*;
#(
   parameter int DIV_W = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic              done,
   output logic [DIV_W-1:0]  remainder
);

   localparam int STEP_W = $clog2(WORD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;

   always_comb begin
      trial    = {rem_ff, shift_ff[WORD_W-1]};
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[WORD_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = DIV_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = DIV_W'(trial);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/uswr_datapath.sv
// Sampler datapath: permutation store, taken count, pool register, result word.
// Depends on uswr_pkg and uswr_mod_unit.
`timescale 1ns / 1ps

module uswr_datapath
   import uswr_pkg::*;
#(
   parameter int POOL_MAX = POOL_MAX_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data,
   input  op_type            req_op,
   input  logic [WORD_W-1:0] req_word,
   input  logic [POS_W-1:0]  req_pos,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [POS_W-1:0]  rsp_picked,
   output status_type        rsp_status,
   output logic [CNT_W-1:0]  rsp_count
);

   localparam int AW     = $clog2(POOL_MAX);
   localparam int CW     = $clog2(POOL_MAX + 1);
   localparam int CMP_W  = (CW > CNT_W) ? CW : CNT_W;
   localparam int PCMP_W = (CW > POS_W) ? CW : POS_W;
   localparam int XW     = (AW > POS_W) ? AW : POS_W;

   logic [CNT_W-1:0]  pool_count_ff, pool_count_in;
   op_type            op_ff, op_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CW-1:0]     taken_ff, taken_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  picked_ff, picked_in;
   status_type        status_ff, status_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [AW-1:0]     perm_mem [POOL_MAX];
   logic [AW-1:0]     rda_ff, rdb_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr, wr_data;

   logic [CW-1:0]     pool_n;
   logic              exhausted, order_bad, sweep_last;
   logic              mod_done;
   logic [CW-1:0]     mod_rem;

   always_comb begin
      if (CMP_W'(pool_count_ff) >= CMP_W'(POOL_MAX)) begin
         pool_n = CW'(POOL_MAX);
      end else begin
         pool_n = CW'(pool_count_ff);
      end
      exhausted  = taken_ff >= pool_n;
      order_bad  = (PCMP_W'(pos_ff) >= PCMP_W'(pool_n)) ||
                   (PCMP_W'(pos_ff) < PCMP_W'(taken_ff)) ||
                   (XW'(rdb_ff) != XW'(pos_ff));
      sweep_last = sweep_ff == AW'(POOL_MAX - 1);
   end

   uswr_mod_unit #(
      .DIV_W (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (word_ff),
      .divisor   (pool_n - taken_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      pool_count_in = csr_wr_en ? csr_wr_data : pool_count_ff;
      op_in   = cmd.capture ? req_op   : op_ff;
      word_in = cmd.capture ? req_word : word_ff;
      pos_in  = cmd.capture ? req_pos  : pos_ff;

      slot_in = slot_ff;
      if (cmd.set_slot) begin
         if (op_ff == OP_DRAW) begin
            slot_in = AW'(taken_ff + mod_rem);
         end else begin
            slot_in = AW'(pos_ff);
         end
      end

      sweep_in = sweep_ff;
      if (cmd.sweep_wr) begin
         sweep_in = sweep_last ? '0 : sweep_ff + 1'b1;
      end

      wr_en   = cmd.sweep_wr || cmd.wr_a || cmd.wr_b;
      wr_addr = slot_ff;
      wr_data = rda_ff;
      if (cmd.sweep_wr) begin
         wr_addr = sweep_ff;
         wr_data = sweep_ff;
      end else if (cmd.wr_a) begin
         wr_addr = AW'(taken_ff);
         wr_data = rdb_ff;
      end

      taken_in  = taken_ff;
      picked_in = picked_ff;
      status_in = status_ff;
      count_in  = count_ff;
      if (cmd.finish) begin
         picked_in = '0;
         status_in = ST_OK;
         case (op_ff)
            OP_DRAW: begin
               if (exhausted) begin
                  status_in = ST_EXHAUSTED;
               end else begin
                  picked_in = POS_W'(rdb_ff);
                  taken_in  = taken_ff + 1'b1;
               end
            end
            OP_DELETE: begin
               if (exhausted) begin
                  status_in = ST_EXHAUSTED;
               end else if (order_bad) begin
                  status_in = ST_ORDER;
               end else begin
                  taken_in = taken_ff + 1'b1;
               end
            end
            OP_RESET: begin
               taken_in = '0;
            end
            default: begin
               taken_in = taken_ff;
            end
         endcase
         count_in = CNT_W'(taken_in);
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_count_ff <= POOL_COUNT_RESET;
         taken_ff      <= '0;
         sweep_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pool_count_ff <= pool_count_in;
         taken_ff      <= taken_in;
         sweep_ff      <= sweep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff     <= op_in;
      word_ff   <= word_in;
      pos_ff    <= pos_in;
      slot_ff   <= slot_in;
      picked_ff <= picked_in;
      status_ff <= status_in;
      count_ff  <= count_in;
   end

   // permutation store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rda_ff <= perm_mem[AW'(taken_ff)];
         rdb_ff <= perm_mem[slot_ff];
      end
   end

   always_comb begin
      stat.op         = op_ff;
      stat.exhausted  = exhausted;
      stat.order_bad  = order_bad;
      stat.mod_done   = mod_done;
      stat.sweep_last = sweep_last;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_picked = picked_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;

endmodule

>>> rtl/uswr_ctrl.sv
// Sampler controller: sequences clear pass, remainder, swap, restore sweep and result.
// Depends on uswr_pkg.
`timescale 1ns / 1ps

module uswr_ctrl
   import uswr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_MOD,
      S_READ,
      S_EVAL,
      S_WR_A,
      S_WR_B,
      S_SWEEP,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               OP_DRAW: begin
                  if (stat.exhausted) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.mod_start = 1'b1;
                     state_in      = S_MOD;
                  end
               end
               OP_DELETE: begin
                  if (stat.exhausted) begin
                     state_in = S_FINISH;
                  end else begin
                     cmd.set_slot = 1'b1;
                     state_in     = S_READ;
                  end
               end
               OP_RESET: begin
                  state_in = S_SWEEP;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_MOD: begin
            if (stat.mod_done) begin
               cmd.set_slot = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            if (stat.op == OP_DELETE && stat.order_bad) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_WR_A;
            end
         end
         S_WR_A: begin
            cmd.wr_a = 1'b1;
            state_in = S_WR_B;
         end
         S_WR_B: begin
            cmd.wr_b = 1'b1;
            state_in = S_FINISH;
         end
         S_SWEEP: begin
            cmd.sweep_wr = 1'b1;
            if (stat.sweep_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

>>> rtl/undoable_sampler_without_replacement.sv
// Sampler without replacement over 0..n-1 (partial Fisher-Yates), n = pool_count capped
// at POOL_MAX. Op 0 draws (random word mod free count picks the slot), op 1 deletes a
// position still at its home slot, op 2 restores the identity order; one result word per
// request word. After reset a clear pass over all POOL_MAX slots loads the identity order,
// with req_tready low; csr writes are taken throughout. A draw runs the 31-step remainder
// loop, then a read and a two-write swap on the single-write-port store; a delete skips
// the remainder loop; op 2 rewrites the store. Words are taken one at a time, but the
// result sits in an output register, so a new word is accepted while the previous
// result waits.
// Depends on uswr_pkg, uswr_ctrl, uswr_datapath, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module undoable_sampler_without_replacement
   import uswr_pkg::*;
#(
   parameter int POOL_MAX = POOL_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CNT_W-1:0]       csr_wr_data,  // pool_count
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,    // random_word, position, zero pad
   input  logic [OP_W-1:0]        req_tuser,    // op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,    // picked_value, drawn_count, zero pad
   output logic [ST_W-1:0]        rsp_tuser     // status
);

   cmd_type          cmd;
   stat_type         stat;
   logic [POS_W-1:0] rsp_picked;
   status_type       rsp_status;
   logic [CNT_W-1:0] rsp_count;

   uswr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   uswr_datapath #(
      .POOL_MAX (POOL_MAX)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_op      (req_tuser),
      .req_word    (req_tdata[WORD_W-1:0]),
      .req_pos     (req_tdata[WORD_W+POS_W-1:WORD_W]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_picked  (rsp_picked),
      .rsp_status  (rsp_status),
      .rsp_count   (rsp_count)
   );

   assign rsp_tdata = {(RSP_TDATA_W - POS_W - CNT_W)'(0), rsp_count, rsp_picked};
   assign rsp_tuser = rsp_status;

   `USWR_ASSERT_NEXT(a_one_word_at_a_time, req_tvalid && req_tready, !req_tready, "ready after accept")
   `USWR_ASSERT_NEXT(a_swap_completes, cmd.wr_a, cmd.wr_b, "swap left half done")
   `USWR_ASSERT_IMPLY(a_error_no_pick, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata[POS_W-1:0] == '0, "pick on error")
   `USWR_ASSERT(a_single_writer, !(cmd.sweep_wr && (cmd.wr_a || cmd.wr_b)), "store write clash")

endmodule

>>> tb/sv/undoable_sampler_without_replacement_tb.sv
// Self-checking bench for undoable_sampler_without_replacement: draws, deletes and
// restores over several pool sizes, predicted by a local shuffle model.
// Depends on uswr_pkg and the sampler RTL only.
`timescale 1ns / 1ps

module undoable_sampler_without_replacement_tb;
   import uswr_pkg::*;

   localparam int     POOL_N   = POOL_MAX_DEFAULT;
   localparam op_type OP_SPARE = 2'd3;
   // two copies of the pool: one follows accepted words, one plans the stimulus
   localparam int     ACCEPTED = 0;
   localparam int     PLANNED  = 1;

   typedef struct {
      op_type            op;
      bit [WORD_W-1:0]   word;
      bit [POS_W-1:0]    pos;
   } shuffle_req_type;

   typedef struct {
      bit [POS_W-1:0]    pick;
      status_type        st;
      bit [CNT_W-1:0]    cnt;
   } pick_due_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]       csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;   // random_word, position, zero pad
   logic [OP_W-1:0]        req_tuser   = '0;   // op
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;          // picked_value, drawn_count, zero pad
   logic [ST_W-1:0]        rsp_tuser;          // status

   bit [POS_W-1:0]  slot_value [2][POOL_N];
   bit [POS_W-1:0]  undo_slot  [2][POOL_N];
   int unsigned     drawn      [2];
   int unsigned     pool_limit [2];

   shuffle_req_type pending_reqs [$];
   pick_due_type    picks_due    [$];
   shuffle_req_type next_req;

   bit              req_fired;
   int              fails;
   int              req_total, rsp_total;
   int              op_seen [4];
   int              exhausted_seen, order_seen;
   int              hold_left;
   bit              hold_done;
   logic            quiet;

   assign quiet = (req_total >= 300 && req_total < 520);

   undoable_sampler_without_replacement u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pool_span(input int w);
      return (pool_limit[w] > POOL_N) ? POOL_N : pool_limit[w];
   endfunction

   function automatic void exchange(input int w, input int unsigned a, input int unsigned b);
      bit [POS_W-1:0] tmp;
      tmp              = slot_value[w][a];
      slot_value[w][a] = slot_value[w][b];
      slot_value[w][b] = tmp;
   endfunction

   function automatic pick_due_type shuffle_step(input int w, input op_type op,
                                                 input bit [WORD_W-1:0] rw,
                                                 input bit [POS_W-1:0] pos);
      pick_due_type r;
      int unsigned  n, t, slot;
      n    = pool_span(w);
      t    = drawn[w];
      r.pick = '0;
      r.st   = ST_OK;
      case (op)
         OP_DRAW: begin
            if (t >= n) begin
               r.st = ST_EXHAUSTED;
            end else begin
               slot = t + int'(rw) % (n - t);
               exchange(w, t, slot);
               r.pick          = slot_value[w][t];
               undo_slot[w][t] = POS_W'(slot);
               drawn[w]++;
            end
         end
         OP_DELETE: begin
            if (t >= n) begin
               r.st = ST_EXHAUSTED;
            end else if (pos >= n || pos < t || slot_value[w][pos] != pos) begin
               r.st = ST_ORDER;
            end else begin
               exchange(w, t, pos);
               undo_slot[w][t] = pos;
               drawn[w]++;
            end
         end
         OP_RESET: begin
            while (drawn[w] > 0) begin
               drawn[w]--;
               exchange(w, drawn[w], undo_slot[w][drawn[w]]);
            end
         end
         default: ;
      endcase
      r.cnt = CNT_W'(drawn[w]);
      return r;
   endfunction

   task automatic push_req(input op_type op, input bit [WORD_W-1:0] rw,
                           input bit [POS_W-1:0] pos);
      shuffle_req_type q;
      pick_due_type    unused;
      q.op   = op;
      q.word = rw;
      q.pos  = pos;
      pending_reqs.push_back(q);
      unused = shuffle_step(PLANNED, op, rw, pos);
   endtask

   task automatic plan_random();
      int unsigned     n, t, roll, start, q;
      bit [WORD_W-1:0] rw;
      bit [POS_W-1:0]  pos;
      bit              found;
      n    = pool_span(PLANNED);
      t    = drawn[PLANNED];
      roll = $urandom_range(0, 99);
      rw   = WORD_W'($urandom());
      pos  = POS_W'($urandom_range(0, POOL_N - 1));
      if ($urandom_range(0, 7) == 0)
         rw = $urandom_range(0, 1) ? '1 : WORD_W'($urandom_range(0, 3));
      if (t >= n) begin
         if (roll < 60)      push_req(OP_RESET, rw, pos);
         else if (roll < 80) push_req(OP_DRAW, rw, pos);
         else if (roll < 93) push_req(OP_DELETE, rw, pos);
         else                push_req(OP_SPARE, rw, pos);
      end else if (roll < 60) begin
         push_req(OP_DRAW, rw, pos);
      end else if (roll < 80) begin
         // pick a position still at home, searching upward from a random start
         found = 1'b0;
         start = $urandom_range(t, n - 1);
         for (int k = 0; k < int'(n - t) && !found; k++) begin
            q = t + (start - t + k) % (n - t);
            if (slot_value[PLANNED][q] == q) begin
               found = 1'b1;
               pos   = POS_W'(q);
            end
         end
         push_req(found ? OP_DELETE : OP_DRAW, rw, pos);
      end else if (roll < 88) begin
         push_req(OP_DELETE, rw, pos);
      end else if (roll < 92) begin
         push_req(OP_SPARE, rw, pos);
      end else if (roll < 93) begin
         push_req(OP_RESET, rw, pos);
      end else begin
         push_req(OP_DRAW, rw, pos);
      end
   endtask

   // wait for the block to drain, then give a store rewrite time to finish
   task automatic settle();
      while (pending_reqs.size() != 0 || req_tvalid || picks_due.size() != 0)
         @(posedge clock);
      repeat (POOL_N + 16) @(posedge clock);
   endtask

   task automatic write_pool(input int unsigned v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      pool_limit[ACCEPTED] = v;
      pool_limit[PLANNED]  = v;
   endtask

   task automatic run_pool(input int unsigned v, input int words);
      settle();
      write_pool(v);
      repeat (words) plan_random();
   endtask

   // driver: offer the next word at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
            next_req    = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_req.op;
            req_tdata  <= REQ_TDATA_W'({next_req.pos, next_req.word});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && rsp_total >= 900) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) >= 14);
      end
   end

   // monitor and predictor, both on the rising edge
   always @(posedge clock) begin
      pick_due_type e;
      pick_due_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_total++;
         g.pick = rsp_tdata[POS_W-1:0];
         g.cnt  = rsp_tdata[POS_W +: CNT_W];
         g.st   = rsp_tuser;
         if (g.st == ST_EXHAUSTED) exhausted_seen++;
         if (g.st == ST_ORDER)     order_seen++;
         if (picks_due.size() == 0) begin
            $error("result word with nothing expected");
            fails++;
         end else begin
            e = picks_due.pop_front();
            if (g.pick != e.pick) begin
               $error("picked_value: expected %0d, got %0d", e.pick, g.pick);
               fails++;
            end
            if (g.st != e.st) begin
               $error("status: expected %0d, got %0d", e.st, g.st);
               fails++;
            end
            if (g.cnt != e.cnt) begin
               $error("drawn_count: expected %0d, got %0d", e.cnt, g.cnt);
               fails++;
            end
         end
      end
      req_fired = !reset && req_tvalid && req_tready;
      if (req_fired) begin
         req_total++;
         op_seen[req_tuser]++;
         picks_due.push_back(shuffle_step(ACCEPTED, op_type'(req_tuser),
                                          req_tdata[WORD_W-1:0],
                                          req_tdata[WORD_W +: POS_W]));
      end
   end

   initial begin
      for (int w = 0; w < 2; w++) begin
         for (int i = 0; i < POOL_N; i++) begin
            slot_value[w][i] = POS_W'(i);
            undo_slot[w][i]  = '0;
         end
         drawn[w]      = 0;
         pool_limit[w] = POOL_COUNT_RESET;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, ordering errors, unused op
      push_req(OP_DRAW,   '0, '0);
      push_req(OP_DRAW,   '1, '0);
      push_req(OP_DELETE, '0, '1);
      push_req(OP_DELETE, '0, '0);
      push_req(OP_DELETE, '0, 10'd512);
      push_req(OP_DELETE, '0, 10'd512);
      push_req(OP_SPARE,  '1, '1);
      push_req(OP_RESET,  '1, '1);
      // empty pool
      settle();
      write_pool(0);
      push_req(OP_DRAW,   31'd99, '0);
      push_req(OP_DELETE, '0, 10'd5);
      push_req(OP_RESET,  '0, '0);
      // single position: last free slot, then exhausted
      settle();
      write_pool(1);
      push_req(OP_DRAW,   31'd12345, '0);
      push_req(OP_DRAW,   '1, '0);
      push_req(OP_DELETE, '0, '0);
      push_req(OP_RESET,  '0, '0);
      push_req(OP_DELETE, '0, 10'd1);
      push_req(OP_DELETE, '0, '0);
      push_req(OP_RESET,  '0, '0);
      // register above the store size saturates
      settle();
      write_pool(2047);
      push_req(OP_DRAW,   '1, '0);
      push_req(OP_DELETE, '0, '1);
      push_req(OP_DRAW,   '0, '0);
      push_req(OP_RESET,  '0, '0);

      run_pool(1024, 350);
      run_pool(7, 200);
      run_pool(1, 60);
      run_pool(2047, 200);
      run_pool(33, 250);
      // pool shrunk below the drawn count, then restored
      settle();
      write_pool(1024);
      push_req(OP_RESET, '0, '0);
      repeat (30) push_req(OP_DRAW, WORD_W'($urandom()), POS_W'($urandom()));
      settle();
      write_pool(4);
      push_req(OP_DRAW,   '1, '0);
      push_req(OP_DELETE, '0, 10'd2);
      push_req(OP_DELETE, '0, 10'd900);
      push_req(OP_SPARE,  '0, '0);
      push_req(OP_RESET,  '0, '0);
      push_req(OP_DRAW,   '1, '0);
      run_pool(0, 30);
      run_pool(100, 250);
      run_pool(1024, 350);
      settle();

      $display("%0d words: %0d draws, %0d deletes, %0d restores, %0d unused op",
               req_total, op_seen[OP_DRAW], op_seen[OP_DELETE], op_seen[OP_RESET],
               op_seen[OP_SPARE]);
      $display("pool sizes 0 to 2047; %0d exhausted and %0d out-of-order results",
               exhausted_seen, order_seen);
      if (fails == 0) begin
         $display("undoable_sampler_without_replacement: match");
      end else begin
         $display("undoable_sampler_without_replacement: mismatch");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("undoable_sampler_without_replacement: mismatch");
      $finish;
   end

endmodule
